// File: hdl/sorted_list_engine_unit_macros.svh
// Assertion macros used by the sorted list engine checker.
`ifndef SORTED_LIST_ENGINE_UNIT_MACROS_SVH
`define SORTED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication with a delayed consequent, sampled on clk, off during reset.
`define SLEC_ASSERT_THREE(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##3 (cons)) \
		else $error(msg);

`endif

// File: hdl/slec_pkg.sv
// Types and constants of the sorted list engine.
`timescale 1ns / 1ps
package slec_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 6;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic               eval;
		logic               apply_ins;
		logic               apply_rem;
		cmd_t               cmd;
		logic [DATA_W-1:0]  value;
		logic [POS_W-1:0]   position;
		logic               ascending;
		logic [CNT_W-1:0]   count;
	} ctrl_t;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] rd;
	} chain_t;

endpackage

// File: hdl/slec_cell.sv
// One list cell: holds one entry, compares it, and shifts toward a neighbor.
`timescale 1ns / 1ps
module slec_cell import slec_pkg::*; (
	input  logic              clk,
	input  ctrl_t             ctrl,
	input  logic [IDX_W-1:0]  index,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	input  chain_t            prior_in,
	output chain_t            prior_out,
	output logic [DATA_W-1:0] data_out
);

	logic [DATA_W-1:0] entry_q;
	logic              hit_q;
	logic [DATA_W-1:0] rd_q;
	logic              hit_d;
	logic [DATA_W-1:0] rd_d;
	logic              in_list;
	logic              at_tail;
	logic              goes_before;

	always_comb begin
		in_list     = CNT_W'(index) < ctrl.count;
		at_tail     = CNT_W'(index) == ctrl.count;
		goes_before = ctrl.ascending ? ($signed(ctrl.value) <= $signed(entry_q))
		                             : ($signed(ctrl.value) >= $signed(entry_q));
		hit_d = 1'b0;
		rd_d  = '0;
		case (ctrl.cmd)
			CMD_INSERT: begin
				hit_d = (in_list && goes_before) || at_tail;
			end
			CMD_REMOVE: begin
				hit_d = in_list && (entry_q == ctrl.value);
			end
			CMD_READ: begin
				if (CMP_W'(index) == CMP_W'(ctrl.position)) begin
					rd_d = entry_q;
				end
			end
			default: begin
				hit_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			hit_q <= hit_d;
			rd_q  <= rd_d;
		end
		if (ctrl.apply_ins) begin
			if (prior_in.found) begin
				entry_q <= left_data;
			end else if (hit_q) begin
				entry_q <= ctrl.value;
			end
		end else if (ctrl.apply_rem) begin
			if (prior_in.found || hit_q) begin
				entry_q <= right_data;
			end
		end
	end

	assign prior_out.found = prior_in.found | hit_q;
	assign prior_out.rd    = prior_in.rd | rd_q;
	assign data_out        = entry_q;

endmodule

// File: hdl/sorted_list_engine_unit.sv
// Top level of the sorted list engine: command sequencer and row of cells.
`timescale 1ns / 1ps
// Keeps up to 64 signed 32-bit words sorted in the order set by cfg_wr_data
// (1 ascending, 0 descending; write it only while the list is empty and busy
// is low). Pulse start with command, value and position while busy is low.
// Every command runs through a compare state, in which all cells compare in
// parallel, an apply state, in which the row shifts and the first-hit chain
// through the cells resolves, and one output register stage. done is high
// for exactly one cycle with status, read_value, entry_count and the flags;
// there is no backpressure, so capture it then. A new start is taken in the
// same cycle that done is shown; until then busy is high and no start is
// taken.
module sorted_list_engine_unit import slec_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic signed [DATA_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	input  logic                     cfg_wr_en,
	input  logic                     cfg_wr_data,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         entry_count,
	output logic                     empty_flag,
	output logic                     full_flag
);

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] value_q;
	logic [POS_W-1:0]  position_q;
	logic              ascending_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              done_q, done_d;
	status_t           status_q, status_d;
	logic [DATA_W-1:0] read_q, read_d;
	logic              full_now;
	logic              pos_ok;
	ctrl_t             ctrl;
	chain_t            chain [0:CAPACITY];
	logic [DATA_W-1:0] cell_data [0:CAPACITY-1];

	assign full_now = count_q == CNT_W'(CAPACITY);
	assign pos_ok   = CMP_W'(position_q) < CMP_W'(count_q);

	always_comb begin
		ctrl.eval      = state_q == S_EVAL;
		ctrl.apply_ins = (state_q == S_APPLY) && (cmd_q == CMD_INSERT) && !full_now;
		ctrl.apply_rem = (state_q == S_APPLY) && (cmd_q == CMD_REMOVE);
		ctrl.cmd       = cmd_q;
		ctrl.value     = value_q;
		ctrl.position  = position_q;
		ctrl.ascending = ascending_q;
		ctrl.count     = count_q;
	end

	assign chain[0] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (g == 0) begin : g_head
			assign left_w = value_q;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign right_w = cell_data[g];
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		slec_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.index     (IDX_W'(g)),
			.left_data (left_w),
			.right_data(right_w),
			.prior_in  (chain[g]),
			.prior_out (chain[g+1]),
			.data_out  (cell_data[g])
		);
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		done_d   = 1'b0;
		status_d = ST_OK;
		read_d   = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				case (cmd_q)
					CMD_INSERT: begin
						if (full_now) begin
							status_d = ST_FULL;
						end else begin
							count_d = count_q + CNT_W'(1);
						end
					end
					CMD_REMOVE: begin
						if (chain[CAPACITY].found) begin
							count_d = count_q - CNT_W'(1);
						end else begin
							status_d = ST_NOT_FOUND;
						end
					end
					CMD_CLEAR: begin
						count_d = '0;
					end
					CMD_READ: begin
						if (pos_ok) begin
							read_d = chain[CAPACITY].rd;
						end else begin
							status_d = ST_BEYOND;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			done_q      <= 1'b0;
			ascending_q <= 1'b1;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			if (cfg_wr_en) begin
				ascending_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q      <= cmd_t'(command);
			value_q    <= value;
			position_q <= position;
		end
		if (state_q == S_APPLY) begin
			status_q <= status_d;
			read_q   <= read_d;
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = read_q;
	assign entry_count = count_q;
	assign empty_flag  = count_q == '0;
	assign full_flag   = full_now;

endmodule

// File: hdl/slec_checker.sv
// Port-level checker for the sorted list engine, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_list_engine_unit_macros.svh"
module slec_checker import slec_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [1:0]               command,
	input logic signed [DATA_W-1:0] value,
	input logic [POS_W-1:0]         position,
	input logic                     cfg_wr_en,
	input logic                     cfg_wr_data,
	input logic                     done,
	input logic [1:0]               status,
	input logic signed [DATA_W-1:0] read_value,
	input logic [CNT_W-1:0]         entry_count,
	input logic                     empty_flag,
	input logic                     full_flag
);

	`SLEC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after start")
	`SLEC_ASSERT_THREE(a_accept_done, start && !busy, done, "no word three cycles after start")
	`SLEC_ASSERT_NOW(a_done_idle, done, !busy, "word shown while busy")
	`SLEC_ASSERT_NOW(a_empty_count, done, empty_flag == (entry_count == '0), "empty flag wrong")
	`SLEC_ASSERT_NOW(a_full_count, done,
		full_flag == (entry_count == CNT_W'(CAPACITY)), "full flag wrong")

endmodule

bind sorted_list_engine_unit slec_checker u_slec_checker (.*);

// File: bench/testbench.sv
// Self-checking sorted list engine bench: directed and random bursts against a predictor.
`timescale 1ns / 1ps
module testbench;
	import slec_pkg::*;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
		logic                     empty;
		logic                     full;
	} list_result_t;

	class list_scoreboard;
		logic signed [DATA_W-1:0] stored[$];
		logic                     ascending = 1'b1;
		list_result_t             expected_results[$];
		int                       mismatches = 0;

		function void report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("%0t ns: %s", $realtime, msg);
		endfunction

		function bit belongs_before(logic signed [DATA_W-1:0] val,
				logic signed [DATA_W-1:0] entry);
			if (ascending)
				return val <= entry;
			return val >= entry;
		endfunction

		function void note_command(cmd_t cmd, logic signed [DATA_W-1:0] val,
				logic [POS_W-1:0] pos);
			list_result_t r;
			int at;
			r.status = ST_OK;
			r.read_value = '0;
			case (cmd)
				CMD_INSERT: begin
					if (stored.size() >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						at = stored.size();
						for (int i = 0; i < stored.size(); i++)
							if (at == stored.size() && belongs_before(val, stored[i]))
								at = i;
						stored.insert(at, val);
					end
				end
				CMD_REMOVE: begin
					at = -1;
					for (int i = 0; i < stored.size(); i++)
						if (at < 0 && stored[i] == val)
							at = i;
					if (at < 0)
						r.status = ST_NOT_FOUND;
					else
						stored.delete(at);
				end
				CMD_CLEAR: stored.delete();
				default: begin
					if (int'(pos) < stored.size())
						r.read_value = stored[pos];
					else
						r.status = ST_BEYOND;
				end
			endcase
			r.count = CNT_W'(stored.size());
			r.empty = (stored.size() == 0);
			r.full  = (stored.size() == CAPACITY);
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] rd,
				logic [CNT_W-1:0] cnt, logic emp, logic ful);
			list_result_t r;
			if (expected_results.size() == 0) begin
				report_mismatch("result word with no command outstanding");
				return;
			end
			r = expected_results.pop_front();
			if (st !== r.status)
				report_mismatch($sformatf("status %0d, want %0d", st, r.status));
			if (rd !== r.read_value)
				report_mismatch($sformatf("read_value %0d, want %0d", rd, r.read_value));
			if (cnt !== r.count)
				report_mismatch($sformatf("entry_count %0d, want %0d", cnt, r.count));
			if (emp !== r.empty)
				report_mismatch($sformatf("empty_flag %0b, want %0b", emp, r.empty));
			if (ful !== r.full)
				report_mismatch($sformatf("full_flag %0b, want %0b", ful, r.full));
		endfunction
	endclass

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               command = CMD_CLEAR;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     cfg_wr_en = 1'b0;
	logic                     cfg_wr_data = 1'b1;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         entry_count;
	logic                     empty_flag;
	logic                     full_flag;

	list_scoreboard sb = new();
	int burst_left = 0;
	int words_sent = 0;

	sorted_list_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.position(position),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.status(status),
		.read_value(read_value),
		.entry_count(entry_count),
		.empty_flag(empty_flag),
		.full_flag(full_flag)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, read_value, entry_count, empty_flag, full_flag);
	end

	task automatic send_command(cmd_t cmd, logic signed [DATA_W-1:0] val,
			logic [POS_W-1:0] pos);
		start    <= 1'b1;
		command  <= cmd;
		value    <= val;
		position <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(cmd, val, pos);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_order(logic asc);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= asc;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.ascending = asc;
		@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 16) - 8;
			4: begin
				case ($urandom_range(0, 3))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_stored();
		if (sb.stored.size() == 0 || $urandom_range(0, 5) == 0)
			return pick_value();
		return sb.stored[$urandom_range(0, sb.stored.size() - 1)];
	endfunction

	function automatic logic [POS_W-1:0] rand_position();
		return POS_W'($urandom_range(0, 63));
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if (sb.stored.size() > 0 && $urandom_range(0, 3) != 0)
			return POS_W'($urandom_range(0, sb.stored.size() - 1));
		return rand_position();
	endfunction

	task automatic run_mixed(int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_command(CMD_INSERT, pick_value(), rand_position());
			else if (pick < 65)
				send_command(CMD_REMOVE, pick_stored(), rand_position());
			else if (pick < 96)
				send_command(CMD_READ, $urandom, pick_position());
			else
				send_command(CMD_CLEAR, $urandom, rand_position());
		end
	endtask

	task automatic run_fill();
		while (sb.stored.size() < CAPACITY) begin
			if ($urandom_range(0, 7) == 0)
				send_command(CMD_READ, $urandom, pick_position());
			else
				send_command(CMD_INSERT, pick_value(), rand_position());
		end
		repeat ($urandom_range(1, 3))
			send_command(CMD_INSERT, pick_value(), rand_position());
		send_command(CMD_READ, $urandom, 6'd63);
		send_command(CMD_READ, $urandom, pick_position());
		if ($urandom_range(0, 1)) begin
			while (sb.stored.size() > 0)
				send_command(CMD_REMOVE, pick_stored(), rand_position());
		end else begin
			run_mixed($urandom_range(5, 20));
			send_command(CMD_CLEAR, $urandom, rand_position());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_order(1'b1);

		send_command(CMD_READ, 0, 6'd0);
		send_command(CMD_REMOVE, 7, 6'd0);
		send_command(CMD_CLEAR, 0, 6'd0);
		send_command(CMD_INSERT, 0, 6'd0);
		send_command(CMD_INSERT, VAL_MAX, 6'd63);
		send_command(CMD_INSERT, VAL_MIN, 6'd0);
		send_command(CMD_INSERT, -1, 6'd0);
		send_command(CMD_INSERT, 0, 6'd0);
		send_command(CMD_READ, 0, 6'd0);
		send_command(CMD_READ, 0, 6'd4);
		send_command(CMD_READ, 0, 6'd5);
		send_command(CMD_READ, -1, 6'd63);
		send_command(CMD_REMOVE, 5, 6'd0);
		send_command(CMD_REMOVE, 0, 6'd0);
		send_command(CMD_REMOVE, VAL_MIN, 6'd0);
		write_order(1'b0);
		send_command(CMD_INSERT, 1, 6'd0);
		send_command(CMD_INSERT, VAL_MIN, 6'd0);
		send_command(CMD_READ, 0, 6'd0);
		send_command(CMD_READ, 0, 6'd4);
		send_command(CMD_CLEAR, 0, 6'd0);
		send_command(CMD_INSERT, 3, 6'd0);
		send_command(CMD_INSERT, 9, 6'd0);
		send_command(CMD_INSERT, 3, 6'd0);
		send_command(CMD_READ, 0, 6'd1);
		send_command(CMD_REMOVE, VAL_MAX, 6'd0);

		words_sent = 0;
		while (words_sent < 500) begin
			if ($urandom_range(0, 1)) begin
				if ($urandom_range(0, 2) != 0) begin
					send_command(CMD_CLEAR, $urandom, rand_position());
				end
				write_order(1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 3) == 0)
				run_fill();
			else
				run_mixed($urandom_range(20, 60));
		end

		drain();
		if (sb.expected_results.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.expected_results.size()));
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
